// ----- rtl/core/dng_pkg.sv -----
// dng_pkg: shared types, constants and helper functions of the dither noise generator
// used by dng_mul, dng_seq and dither_noise_generator; no dependencies
`timescale 1ns / 1ps

package dng_pkg;

  localparam int unsigned SeedW   = 32;
  localparam int unsigned ValueW  = 13;
  localparam int unsigned SpreadW = 12;
  localparam int unsigned ScaleW  = 16;
  localparam int unsigned MulW    = 64;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned UnitW   = 52;
  localparam int unsigned SqW     = 104;
  localparam int unsigned NormW   = 103;
  localparam int unsigned ExpW    = 7;
  localparam int unsigned SumTop  = 102;
  localparam int unsigned SdW     = 62;

  localparam logic [SeedW-1:0]  LcgMul    = 32'd1664525;
  localparam logic [SeedW-1:0]  LcgAdd    = 32'd1013904223;
  localparam logic [MulW-1:0]   TwoLn2Q62 = 64'h58B9_0BFB_E8E7_BCD6;
  localparam logic [SpreadW-1:0] ValueMax = 12'd4095;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ALG_MIX   = 2'd0,
    ALG_LCG   = 2'd1,
    ALG_GAUSS = 2'd2
  } alg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LCG,
    ST_UMAG,
    ST_GX,
    ST_GY,
    ST_GXX,
    ST_GYY,
    ST_GCHK,
    ST_GNORM,
    ST_GSQ,
    ST_GLN,
    ST_GDIVI,
    ST_GDIV,
    ST_GP,
    ST_GSQRT,
    ST_GT,
    ST_GMAG,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic                operation;
    logic [1:0]          algorithm;
    logic [SpreadW-1:0]  spread;
    logic [ScaleW-1:0]   gauss_scale;
    logic [SeedW-1:0]    new_seed;
  } item_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [SeedW-1:0]         seed_after;
  } item_out_t;

  typedef struct packed {
    logic            req;
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] prod;
  } mul_rsp_t;

  function automatic logic [SeedW-1:0] next_mix(logic [SeedW-1:0] s);
    logic [SeedW-1:0] a;
    logic [SeedW-1:0] t;
    a = s << 13;
    t = ((a ^ s) >> 17) ^ a ^ s;
    return (t << 5) ^ t;
  endfunction

  // sign in the top bit, magnitude of (m - 2^51) below
  function automatic logic [UnitW:0] unit_mag(logic [SeedW-1:0] s);
    logic [UnitW-1:0] m;
    logic [UnitW-1:0] half;
    half = {1'b1, {(UnitW-1){1'b0}}};
    m    = {s, s[SeedW-1:12]};
    if (!m[UnitW-1]) begin
      return {1'b1, half - m};
    end
    return {1'b0, m - half};
  endfunction

endpackage

// ----- rtl/core/dng_mul.sv -----
// dng_mul: shared 64x64 multiplier built from four 32x32 partial products over cycles
// depends on dng_pkg
`timescale 1ns / 1ps

module dng_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dng_pkg::mul_req_t req_i,
  output dng_pkg::mul_rsp_t rsp_o
);
  import dng_pkg::*;

  localparam int unsigned HalfW = MulW / 2;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             pp_vld_q, pp_vld_d;
  logic             start;
  logic [MulW-1:0]  a_q, b_q;
  logic [MulW-1:0]  pp_q, pp_d;
  logic [1:0]       pp_sh_q;
  logic [ProdW-1:0] acc_q, acc_d;
  logic [HalfW-1:0] a_half, b_half;

  assign start    = req_i.req && !busy_q && !done_q;
  assign busy_d   = start || (busy_q && (cnt_q != 3'd4));
  assign done_d   = busy_q && (cnt_q == 3'd4);
  assign pp_vld_d = busy_q && (cnt_q != 3'd4);

  always_comb begin
    cnt_d = cnt_q;
    if (start) begin
      cnt_d = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 3'd1;
    end
  end

  assign a_half = cnt_q[1] ? a_q[MulW-1:HalfW] : a_q[HalfW-1:0];
  assign b_half = cnt_q[0] ? b_q[MulW-1:HalfW] : b_q[HalfW-1:0];
  assign pp_d   = a_half * b_half;
  assign acc_d  = acc_q + (pp_vld_q ? (ProdW'(pp_q) << {pp_sh_q, 5'b0}) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      pp_vld_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
      pp_vld_q <= pp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q    <= pp_d;
      pp_sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      acc_q   <= acc_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done held for more than one cycle");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (cnt_q == 3'd4)) |=> (done_q && !busy_q))
    else $error("multiplier did not finish after the last partial product");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= 3'd4))
    else $error("multiplier step count out of range");

endmodule

// ----- rtl/core/dng_seq.sv -----
// dng_seq: sequencer and datapath registers for the seed, uniform and polar gaussian draws
// drives the shared multiplier dng_mul; depends on dng_pkg
`timescale 1ns / 1ps

module dng_seq #(
  parameter int unsigned SPREAD_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  dng_pkg::item_in_t  item_i,
  output logic               idle_o,
  output logic               res_valid_o,
  input  logic               res_ack_i,
  output dng_pkg::item_out_t res_o,
  output dng_pkg::mul_req_t  mul_req_o,
  input  dng_pkg::mul_rsp_t  mul_rsp_i
);
  import dng_pkg::*;

  localparam int unsigned F      = FRACTION_BITS;
  localparam int unsigned SpW    = SPREAD_BITS;
  localparam int unsigned MagW   = SpW + 1;
  localparam int unsigned CntW   = $clog2(F + 5);
  localparam int unsigned ZW     = F + 1;
  localparam int unsigned DW     = F + ExpW;
  localparam int unsigned GW     = F + 8;
  localparam int unsigned QW     = F + 1;
  localparam int unsigned RootW  = F + 5;
  localparam int unsigned NW     = 2 * F + 10;
  localparam int unsigned RemW   = F + 10;
  localparam int unsigned URndW  = UnitW + SpW + 1;
  localparam int unsigned GRndW  = F + SpW + 1;

  seq_state_e state_q, state_d;
  logic [SeedW-1:0] seed_q, seed_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [SpW-1:0]    spread_q;
  logic [ScaleW-1:0] scale_q;
  logic [UnitW-1:0]  xmag_q, ymag_q;
  logic              yneg_q, neg_q;
  logic [SqW-1:0]    s_q, y2_q;
  logic [NormW-1:0]  norm_q;
  logic [ExpW-1:0]   e_q;
  logic [ZW-1:0]     z_q;
  logic [F-1:0]      l_q;
  logic [GW-1:0]     g_q;
  logic [SdW-1:0]    sd_q;
  logic [SdW:0]      r_q;
  logic [QW-1:0]     q_q;
  logic [NW-1:0]     n_q;
  logic [RemW-3:0]   rem_q;
  logic [RootW-1:0]  root_q;
  logic [F-1:0]      t_q;
  logic [MagW-1:0]   mag_q;

  logic [SeedW-1:0]  lcg_next;
  logic [UnitW:0]    seed_unit;
  logic [UnitW:0]    lcg_unit;
  logic [URndW-1:0]  u_rnd;
  logic [GRndW-1:0]  g_rnd;
  logic              chk_reject;
  logic [F+1:0]      zz;
  logic [DW-1:0]     d_val;
  logic [ExpW-1:0]   k_sh;
  logic [SqW-1:0]    s_shift, y_shift;
  logic [SdW:0]      rr;
  logic [RemW-1:0]   rem2, trial;
  logic [GW-1:0]     t_full;
  logic              t_reject;
  logic [SpreadW-1:0] mag_lim;
  logic [ValueW-1:0]  val_abs;

  assign lcg_next  = mul_rsp_i.prod[SeedW-1:0] + LcgAdd;
  assign seed_unit = unit_mag(seed_q);
  assign lcg_unit  = unit_mag(lcg_next);
  assign u_rnd     = mul_rsp_i.prod[URndW-1:0] + (URndW'(1) << (UnitW - 2));
  assign g_rnd     = mul_rsp_i.prod[GRndW-1:0] + (GRndW'(1) << (F - 1));
  assign chk_reject = (s_q == '0) || (s_q > (SqW'(1) << SumTop));
  assign zz        = mul_rsp_i.prod[F +: F + 2];
  assign d_val     = {ExpW'(SumTop) - e_q, {F{1'b0}}} - DW'(l_q);
  assign k_sh      = (e_q >= 7'd62) ? (e_q - 7'd61) : '0;
  assign s_shift   = s_q >> k_sh;
  assign y_shift   = y2_q >> k_sh;
  assign rr        = (cnt_q == '0) ? r_q : {r_q[SdW-1:0], 1'b0};
  assign rem2      = {rem_q, n_q[NW-1 -: 2]};
  assign trial     = RemW'({root_q, 2'b01});
  assign t_full    = mul_rsp_i.prod[12 +: GW];
  assign t_reject  = (t_full >= (GW'(1) << F));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (item_i.operation == OP_LOAD) begin
            state_d = ST_DONE;
          end else begin
            case (item_i.algorithm)
              ALG_MIX:   state_d = ST_UMAG;
              ALG_LCG:   state_d = ST_LCG;
              ALG_GAUSS: state_d = ST_GX;
              default:   state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_LCG:   if (mul_rsp_i.done) state_d = ST_UMAG;
      ST_UMAG:  if (mul_rsp_i.done) state_d = ST_DONE;
      ST_GX:    if (mul_rsp_i.done) state_d = ST_GY;
      ST_GY:    if (mul_rsp_i.done) state_d = ST_GXX;
      ST_GXX:   if (mul_rsp_i.done) state_d = ST_GYY;
      ST_GYY:   if (mul_rsp_i.done) state_d = ST_GCHK;
      ST_GCHK:  state_d = chk_reject ? ST_GX : ST_GNORM;
      ST_GNORM: if (norm_q[NormW-1]) state_d = ST_GSQ;
      ST_GSQ:   if (mul_rsp_i.done && (cnt_q == CntW'(F - 1))) state_d = ST_GLN;
      ST_GLN:   if (mul_rsp_i.done) state_d = ST_GDIVI;
      ST_GDIVI: state_d = ST_GDIV;
      ST_GDIV:  if (cnt_q == CntW'(F)) state_d = ST_GP;
      ST_GP:    if (mul_rsp_i.done) state_d = ST_GSQRT;
      ST_GSQRT: if (cnt_q == CntW'(F + 4)) state_d = ST_GT;
      ST_GT:    if (mul_rsp_i.done) state_d = t_reject ? ST_GX : ST_GMAG;
      ST_GMAG:  if (mul_rsp_i.done) state_d = ST_DONE;
      ST_DONE:  if (res_ack_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs: multiplier requests, seed and step counter
  always_comb begin
    mul_req_o = '0;
    seed_d    = seed_q;
    cnt_d     = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (item_i.operation == OP_LOAD) begin
            seed_d = item_i.new_seed;
          end else if (item_i.algorithm == ALG_MIX) begin
            seed_d = next_mix(seed_q);
          end
        end
      end
      ST_LCG, ST_GX, ST_GY: begin
        mul_req_o.req = 1'b1;
        mul_req_o.a   = MulW'(seed_q);
        mul_req_o.b   = MulW'(LcgMul);
        if (mul_rsp_i.done) seed_d = lcg_next;
      end
      ST_UMAG: begin
        mul_req_o.req = 1'b1;
        mul_req_o.a   = MulW'(seed_unit[UnitW-1:0]);
        mul_req_o.b   = MulW'(spread_q);
      end
      ST_GXX: begin
        mul_req_o.req = 1'b1;
        mul_req_o.a   = MulW'(xmag_q);
        mul_req_o.b   = MulW'(xmag_q);
      end
      ST_GYY: begin
        mul_req_o.req = 1'b1;
        mul_req_o.a   = MulW'(ymag_q);
        mul_req_o.b   = MulW'(ymag_q);
      end
      ST_GNORM: begin
        if (norm_q[NormW-1]) cnt_d = '0;
      end
      ST_GSQ: begin
        mul_req_o.req = 1'b1;
        mul_req_o.a   = MulW'(z_q);
        mul_req_o.b   = MulW'(z_q);
        if (mul_rsp_i.done) cnt_d = cnt_q + CntW'(1);
      end
      ST_GLN: begin
        mul_req_o.req = 1'b1;
        mul_req_o.a   = MulW'(d_val);
        mul_req_o.b   = TwoLn2Q62;
      end
      ST_GDIVI: cnt_d = '0;
      ST_GDIV:  cnt_d = cnt_q + CntW'(1);
      ST_GP: begin
        mul_req_o.req = 1'b1;
        mul_req_o.a   = MulW'(q_q);
        mul_req_o.b   = MulW'(g_q);
        if (mul_rsp_i.done) cnt_d = '0;
      end
      ST_GSQRT: cnt_d = cnt_q + CntW'(1);
      ST_GT: begin
        mul_req_o.req = 1'b1;
        mul_req_o.a   = MulW'(scale_q);
        mul_req_o.b   = MulW'(root_q);
      end
      ST_GMAG: begin
        mul_req_o.req = 1'b1;
        mul_req_o.a   = MulW'(t_q);
        mul_req_o.b   = MulW'(spread_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seed_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          spread_q <= SpW'(item_i.spread);
          scale_q  <= item_i.gauss_scale;
          mag_q    <= '0;
          neg_q    <= 1'b0;
        end
      end
      ST_UMAG: begin
        if (mul_rsp_i.done) begin
          mag_q <= u_rnd[UnitW-1 +: MagW];
          neg_q <= seed_unit[UnitW];
        end
      end
      ST_GX: if (mul_rsp_i.done) xmag_q <= lcg_unit[UnitW-1:0];
      ST_GY: begin
        if (mul_rsp_i.done) begin
          ymag_q <= lcg_unit[UnitW-1:0];
          yneg_q <= lcg_unit[UnitW];
        end
      end
      ST_GXX: if (mul_rsp_i.done) s_q <= mul_rsp_i.prod[SqW-1:0];
      ST_GYY: begin
        if (mul_rsp_i.done) begin
          y2_q <= mul_rsp_i.prod[SqW-1:0];
          s_q  <= s_q + mul_rsp_i.prod[SqW-1:0];
        end
      end
      ST_GCHK: begin
        norm_q <= s_q[NormW-1:0];
        e_q    <= ExpW'(SumTop);
      end
      ST_GNORM: begin
        if (norm_q[NormW-1]) begin
          z_q <= norm_q[NormW-1 -: ZW];
          l_q <= '0;
        end else begin
          norm_q <= norm_q << 1;
          e_q    <= e_q - ExpW'(1);
        end
      end
      ST_GSQ: begin
        // squared mantissa past two gives the next log bit
        if (mul_rsp_i.done) begin
          if (zz[F+1]) begin
            z_q <= zz[F+1:1];
            l_q <= {l_q[F-2:0], 1'b1};
          end else begin
            z_q <= zz[F:0];
            l_q <= {l_q[F-2:0], 1'b0};
          end
        end
      end
      ST_GLN: if (mul_rsp_i.done) g_q <= mul_rsp_i.prod[62 +: GW];
      ST_GDIVI: begin
        sd_q <= s_shift[SdW-1:0];
        r_q  <= {1'b0, y_shift[SdW-1:0]};
        q_q  <= '0;
      end
      ST_GDIV: begin
        if (rr >= {1'b0, sd_q}) begin
          r_q <= rr - {1'b0, sd_q};
          q_q <= {q_q[QW-2:0], 1'b1};
        end else begin
          r_q <= rr;
          q_q <= {q_q[QW-2:0], 1'b0};
        end
      end
      ST_GP: begin
        if (mul_rsp_i.done) begin
          n_q    <= NW'({mul_rsp_i.prod[F +: GW], {F{1'b0}}});
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      ST_GSQRT: begin
        // restoring square root, two radicand bits per step
        if (rem2 >= trial) begin
          rem_q  <= rem2[RemW-3:0] - trial[RemW-3:0];
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem2[RemW-3:0];
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
        n_q <= n_q << 2;
      end
      ST_GT: begin
        if (mul_rsp_i.done && !t_reject) begin
          t_q   <= t_full[F-1:0];
          neg_q <= yneg_q;
        end
      end
      ST_GMAG: if (mul_rsp_i.done) mag_q <= g_rnd[F +: MagW];
      default: ;
    endcase
  end

  assign mag_lim = (mag_q > MagW'(ValueMax)) ? ValueMax : SpreadW'(mag_q);
  assign val_abs = {1'b0, mag_lim};

  assign idle_o           = (state_q == ST_IDLE);
  assign res_valid_o      = (state_q == ST_DONE);
  assign res_o.value      = neg_q ? (ValueW'(0) - val_abs) : val_abs;
  assign res_o.seed_after = seed_q;

  a_idle_no_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |-> !mul_req_o.req)
    else $error("multiplier requested outside a working state");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GDIV) |-> (sd_q != '0))
    else $error("division by zero in gaussian draw");

  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (mag_q <= MagW'(spread_q)))
    else $error("result magnitude above spread");

endmodule

// ----- rtl/core/dither_noise_generator.sv -----
// dither_noise_generator: top level, one item at a time with a registered output stage.
// Gaussian: candidate pairs are drawn on the shared multiplier and the log, divide and square root loops,
// repeated on rejection, then scaled and handed over.
// A new transfer is taken once the result is in the output stage.
// Reset: asynchronous, clears the seed to zero and all control state; no clearing pass.
`timescale 1ns / 1ps

module dither_noise_generator #(
  parameter int unsigned SPREAD_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dng_pkg::item_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dng_pkg::item_out_t out_data_o
);
  import dng_pkg::*;

  logic      seq_idle;
  logic      start;
  logic      res_valid;
  logic      res_ack;
  item_out_t res;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  logic      out_valid_q, out_valid_d;
  item_out_t out_data_q;

  assign start      = in_valid_i && seq_idle;
  assign in_stall_o = !seq_idle;
  // result moves on when the output stage is empty or being emptied
  assign res_ack    = res_valid && (!out_valid_q || !out_stall_i);

  dng_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  dng_seq #(
    .SPREAD_BITS   (SPREAD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (in_data_i),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_ack_i   (res_ack),
    .res_o       (res),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ack) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took a transfer without going busy");

  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ack |=> (out_valid_o && !res_valid))
    else $error("result not moved into the output stage");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.value != 13'h1000))
    else $error("value outside the symmetric range");

endmodule

// ----- test/dither_noise_generator_tb.sv -----
// dither_noise_generator_tb: self-checking testbench for the dither noise generator
// predicts every result with its own bit-exact model of the seed algorithms; needs dng_pkg
`timescale 1ns / 1ps

module dither_noise_generator_tb;
  import dng_pkg::*;

  localparam int unsigned FracBits = 32;
  localparam logic [1:0] AlgUnused = 2'd3;
  localparam int unsigned WatchLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  item_in_t in_data = '0;
  logic in_stall_o;
  logic out_valid_o;
  item_out_t out_data_o;

  item_out_t expected_q[$];
  logic [SeedW-1:0] model_seed = '0;
  int mismatches = 0;
  int hold_left = 0;
  int stall_run = 0;
  bit no_idle = 1'b0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  dither_noise_generator DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o(out_data_o)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [SeedW-1:0] lcg_next(logic [SeedW-1:0] s);
    return s * LcgMul + LcgAdd;
  endfunction

  function automatic logic [63:0] unit_magnitude(logic [SeedW-1:0] s, output logic neg);
    logic [51:0] m;
    m = {s, s[31:12]};
    neg = ~m[51];
    return neg ? 64'(52'h8_0000_0000_0000 - m) : 64'(m - 52'h8_0000_0000_0000);
  endfunction

  // floor(a*b / 2^sh) saturated to all ones
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    if ((p >> (64 + sh)) != 0) return '1;
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] round_scale(logic [63:0] mag, logic [63:0] rng,
                                              int unsigned sh);
    logic [127:0] p;
    p = 128'(mag) * 128'(rng) + (128'(1) << (sh - 1));
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] gauss_magnitude(inout logic [SeedW-1:0] s,
                                                  input logic [15:0] scale,
                                                  output logic neg);
    logic xn, yn;
    logic [63:0] xm, ym, z, l, d, g, sd, yd, q, r, p, root, t;
    logic [127:0] sum, ysq, lim, thl;
    int e, k;
    forever begin
      s = lcg_next(s);
      xm = unit_magnitude(s, xn);
      s = lcg_next(s);
      ym = unit_magnitude(s, yn);
      ysq = 128'(ym) * 128'(ym);
      sum = 128'(xm) * 128'(xm) + ysq;
      lim = 128'(1) << 102;
      if (sum == 0 || sum > lim) continue;
      e = 127;
      while (e > 0 && !sum[e]) e--;
      z = (e >= FracBits) ? 64'(sum >> (e - FracBits)) : (sum[63:0] << (FracBits - e));
      l = '0;
      for (int i = 1; i <= FracBits; i++) begin
        z = mul_shift(z, z, FracBits);
        if (z >= (64'd1 << (FracBits + 1))) begin
          z = z >> 1;
          l[FracBits-i] = 1'b1;
        end
      end
      d = (64'(102 - e) << FracBits) - l;
      g = mul_shift(d, TwoLn2Q62, 62);
      k = (e >= 62) ? e - 61 : 0;
      sd = 64'(sum >> k);
      yd = 64'(ysq >> k);
      q = '0;
      r = yd;
      if (r >= sd) begin
        q = 64'd1;
        r = r - sd;
      end
      for (int i = 0; i < FracBits; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= sd) begin
          r = r - sd;
          q[0] = 1'b1;
        end
      end
      p = mul_shift(q, g, FracBits);
      thl = 128'(p) << FracBits;
      root = '0;
      for (int b = FracBits + 4; b >= 0; b--) begin
        t = root | (64'd1 << b);
        if (128'(t) * 128'(t) <= thl) root = t;
      end
      t = mul_shift(64'(scale), root, 12);
      if (t < (64'd1 << FracBits)) begin
        neg = yn;
        return t;
      end
    end
  endfunction

  // advances the model seed and returns the result this item should produce
  function automatic item_out_t predict_noise(item_in_t it);
    item_out_t res;
    logic [63:0] mag;
    logic neg;
    mag = '0;
    neg = 1'b0;
    if (it.operation == OP_LOAD) begin
      model_seed = it.new_seed;
    end else if (it.algorithm == ALG_MIX || it.algorithm == ALG_LCG) begin
      model_seed = (it.algorithm == ALG_MIX) ? next_mix(model_seed) : lcg_next(model_seed);
      mag = round_scale(unit_magnitude(model_seed, neg), 64'(it.spread), 51);
    end else if (it.algorithm == ALG_GAUSS) begin
      mag = gauss_magnitude(model_seed, it.gauss_scale, neg);
      mag = round_scale(mag, 64'(it.spread), FracBits);
    end
    if (mag > 64'(ValueMax)) mag = 64'(ValueMax);
    res.value = neg ? -mag[12:0] : mag[12:0];
    res.seed_after = model_seed;
    return res;
  endfunction

  task automatic send_item(item_in_t it);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    expected_q.push_back(predict_noise(it));
  endtask

  // sender pauses until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic item_in_t make_item(logic op, logic [1:0] alg, logic [11:0] spr,
                                         logic [15:0] scl, logic [31:0] sd);
    item_in_t it;
    it.operation = op;
    it.algorithm = alg;
    it.spread = spr;
    it.gauss_scale = scl;
    it.new_seed = sd;
    return it;
  endfunction

  function automatic item_in_t random_item();
    int r;
    logic [15:0] scl;
    r = $urandom_range(0, 99);
    scl = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
    if (r < 12)
      return make_item(OP_LOAD, 2'($urandom), 12'($urandom), scl, $urandom);
    if (r < 15)
      return make_item(OP_DRAW, AlgUnused, 12'($urandom), scl, $urandom);
    if (r < 40)
      return make_item(OP_DRAW, ALG_GAUSS, 12'($urandom), scl, $urandom);
    return make_item(OP_DRAW, ($urandom_range(0, 1) != 0) ? ALG_LCG : ALG_MIX,
                     ($urandom_range(0, 7) == 0) ? 12'd4095 : 12'($urandom), scl, $urandom);
  endfunction

  task automatic test_directed();
    send_item(make_item(OP_DRAW, ALG_MIX, 12'd4095, 16'd0, 32'd0));
    send_item(make_item(OP_DRAW, ALG_LCG, 12'd0, 16'd0, 32'd0));
    send_item(make_item(OP_DRAW, ALG_LCG, 12'd4095, 16'd0, 32'd0));
    send_item(make_item(OP_LOAD, ALG_MIX, 12'd4095, 16'hffff, 32'hffff_ffff));
    send_item(make_item(OP_DRAW, ALG_MIX, 12'd4095, 16'hffff, 32'd0));
    send_item(make_item(OP_LOAD, ALG_LCG, 12'd0, 16'd0, 32'h8000_0000));
    send_item(make_item(OP_DRAW, AlgUnused, 12'd4095, 16'hffff, 32'hffff_ffff));
    send_item(make_item(OP_LOAD, ALG_GAUSS, 12'd1, 16'd1, 32'h0000_0001));
    send_item(make_item(OP_DRAW, ALG_GAUSS, 12'd4095, 16'd0, 32'd0));
    send_item(make_item(OP_DRAW, ALG_GAUSS, 12'd4095, 16'd4096, 32'd0));
    send_item(make_item(OP_DRAW, ALG_GAUSS, 12'd0, 16'd4096, 32'd0));
    send_item(make_item(OP_DRAW, ALG_GAUSS, 12'd4095, 16'hffff, 32'd0));
    send_item(make_item(OP_DRAW, ALG_GAUSS, 12'd2048, 16'd1, 32'd0));
    send_item(make_item(OP_LOAD, ALG_MIX, 12'd0, 16'd0, 32'd0));
    send_item(make_item(OP_DRAW, ALG_GAUSS, 12'd4095, 16'd2048, 32'd0));
    send_item(make_item(OP_LOAD, ALG_MIX, 12'd0, 16'd0, 32'h0000_0800));
    send_item(make_item(OP_DRAW, ALG_MIX, 12'd1, 16'd0, 32'd0));
    send_item(make_item(OP_DRAW, ALG_LCG, 12'd1, 16'd0, 32'd0));
    drain();
  endtask

  task automatic test_random(int count);
    repeat (count) send_item(random_item());
    drain();
  endtask

  // receiver holds off while the sender keeps offering transfers
  task automatic test_backpressure();
    hold_left = 300;
    repeat (12) send_item(random_item());
    drain();
  endtask

  task automatic test_no_idle(int count);
    no_idle = 1'b1;
    repeat (count) send_item(random_item());
    drain();
    no_idle = 1'b0;
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    item_out_t exp_item;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: value %0d seed %h",
                     out_data_o.value, out_data_o.seed_after);
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data_o.value !== exp_item.value
              || out_data_o.seed_after !== exp_item.seed_after) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: value exp %0d got %0d, seed exp %h got %h",
                       exp_item.value, out_data_o.value,
                       exp_item.seed_after, out_data_o.seed_after);
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        stall_run = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("dither_noise_generator_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_no_idle(200);
    test_random(420);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("dither_noise_generator_tb: clean");
    end else begin
      $display("dither_noise_generator_tb: errors");
    end
    $finish;
  end

endmodule
